@@ sv/text_line_splitter_top_macros.svh @@
// Assertion macros shared by the line splitter RTL.
`ifndef TEXT_LINE_SPLITTER_TOP_MACROS_SVH
`define TEXT_LINE_SPLITTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/tls_pkg.sv @@
package tls_pkg;

  localparam int CNT_W = 22;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(2097152);

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    MODE_DATA = 1'b0,
    MODE_EOI  = 1'b1
  } mode_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  typedef enum logic {
    REG_MAX_LINE_LENGTH    = 1'b0,
    REG_MAX_BYTES_PER_LINE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    kind_e            kind;
    logic [7:0]       line_byte;
    logic [CNT_W-1:0] line_length;
    logic [CNT_W-1:0] bytes_consumed;
    logic             last;
  } out_t;

  typedef struct packed {
    logic [1:0]       num;
    out_t [1:0]       res;
  } step_t;

  function automatic out_t mk_byte(logic [7:0] b);
    out_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.line_byte = b;
    return r;
  endfunction

  function automatic out_t mk_end(logic [CNT_W-1:0] len, logic [CNT_W-1:0] cons);
    out_t r;
    r = '0;
    r.kind = KIND_END;
    r.line_length = len;
    r.bytes_consumed = cons;
    return r;
  endfunction

endpackage

@@ sv/tls_core.sv @@
module tls_core
  import tls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_index_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic             advance_i,
  input  in_t              item_i,
  output step_t            step_o
);

  logic [CNT_W-1:0] max_len_q, max_bytes_q;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] kept_q, kept_d;
  logic [CNT_W-1:0] cons_q, cons_d;

  logic [CNT_W-1:0] klim, blim, cons_inc;
  logic             is_lf, is_cr, keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= COUNT_LIMIT;
      max_bytes_q <= COUNT_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_LINE_LENGTH:    max_len_q   <= cfg_data_i;
        REG_MAX_BYTES_PER_LINE: max_bytes_q <= cfg_data_i;
        default:                max_len_q   <= max_len_q;
      endcase
    end
  end

  always_comb begin
    klim = (max_len_q > COUNT_LIMIT) ? COUNT_LIMIT : max_len_q;
    if (max_bytes_q == '0) begin
      blim = CNT_W'(1);
    end else if (max_bytes_q > COUNT_LIMIT) begin
      blim = COUNT_LIMIT;
    end else begin
      blim = max_bytes_q;
    end
    cons_inc = (cons_q < COUNT_LIMIT) ? cons_q + 1'b1 : cons_q;
    is_lf    = (item_i.data_byte == CH_LF);
    is_cr    = (item_i.data_byte == CH_CR);
    keep     = 1'b0;

    step_o = '0;
    pend_d = pend_q;
    kept_d = kept_q;
    cons_d = cons_q;

    if (item_i.mode == MODE_EOI) begin
      if (pend_q || cons_q != '0) begin
        step_o.num    = 2'd1;
        step_o.res[0] = mk_end(kept_q, cons_q);
        pend_d = 1'b0;
        kept_d = '0;
        cons_d = '0;
      end
    end else if (pend_q) begin
      if (is_lf) begin
        step_o.num    = 2'd1;
        step_o.res[0] = mk_end(kept_q, cons_inc);
        pend_d = 1'b0;
        kept_d = '0;
        cons_d = '0;
      end else begin
        step_o.num    = 2'd1;
        step_o.res[0] = mk_end(kept_q, cons_q);
        pend_d = is_cr;
        kept_d = '0;
        cons_d = CNT_W'(1);
        if (!is_cr && klim != '0) begin
          step_o.num    = 2'd2;
          step_o.res[1] = mk_byte(item_i.data_byte);
          kept_d = CNT_W'(1);
        end
      end
    end else if (is_lf) begin
      step_o.num    = 2'd1;
      step_o.res[0] = mk_end(kept_q, cons_inc);
      pend_d = 1'b0;
      kept_d = '0;
      cons_d = '0;
    end else begin
      keep   = !is_cr && (kept_q < klim);
      pend_d = is_cr;
      cons_d = cons_inc;
      kept_d = keep ? kept_q + 1'b1 : kept_q;
      if (keep) begin
        step_o.num    = 2'd1;
        step_o.res[0] = mk_byte(item_i.data_byte);
      end
      if (cons_inc >= blim) begin
        if (keep) begin
          step_o.num    = 2'd2;
          step_o.res[1] = mk_end(kept_d, cons_inc);
        end else begin
          step_o.num    = 2'd1;
          step_o.res[0] = mk_end(kept_d, cons_inc);
        end
        pend_d = 1'b0;
        kept_d = '0;
        cons_d = '0;
      end
    end

    if (step_o.num == 2'd2) begin
      step_o.res[1].last = 1'b1;
    end else if (step_o.num == 2'd1) begin
      step_o.res[0].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      kept_q <= '0;
      cons_q <= '0;
    end else if (advance_i) begin
      pend_q <= pend_d;
      kept_q <= kept_d;
      cons_q <= cons_d;
    end
  end

endmodule

@@ sv/text_line_splitter_top.sv @@
// An accepted transaction waits in the input register before its results enter
// the queue. Throughput: one input transaction per cycle while two queue entries
// are free; an input yielding two results needs two output transfers, so the
// output port sets the sustained rate. Results wait in a four-entry queue; input
// is taken while at least two entries are free. Reset clears the line state, the
// queue and the input valid flag, and sets both length registers to 2097152.
module text_line_splitter_top
  import tls_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  cfg_reg_e         cfg_index_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_o
);

  `include "text_line_splitter_top_macros.svh"

  logic                  in_valid_q;
  in_t                   in_q;
  logic                  proc;
  step_t                 step;
  out_t                  fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;
  logic [1:0]            push_num;

  tls_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .advance_i   (proc),
    .item_i      (in_q),
    .step_o      (step)
  );

  assign proc       = in_valid_q && (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign in_ready_o = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_i;
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_o       = fifo_q[rptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign push_num    = proc ? step.num : 2'd0;
  assign count_d     = count_q + FIFO_CNT_W'(push_num) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + FIFO_PTR_W'(push_num);
      rptr_q  <= rptr_q + FIFO_PTR_W'(pop);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_num != 2'd0) begin
      fifo_q[wptr_q] <= step.res[0];
    end
    if (push_num == 2'd2) begin
      fifo_q[wptr_q + FIFO_PTR_W'(1)] <= step.res[1];
    end
  end

  `TLS_ASSERT_NOW(a_fifo_bound, 1'b1, count_q <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overflow")
  `TLS_ASSERT_NOW(a_follower_queued, out_valid_o && !out_o.last, count_q >= FIFO_CNT_W'(2), "result without its follower")
  `TLS_ASSERT_NEXT(a_input_held, in_valid_q && !proc, in_valid_q && $stable(in_q), "stalled input transaction lost")

endmodule
